// ----- design/bilinear_opacity_splat_unit_defines.svh -----
// Assertion macros used by the bilinear opacity splat unit design file.
`ifndef BILINEAR_OPACITY_SPLAT_UNIT_DEFINES_SVH
`define BILINEAR_OPACITY_SPLAT_UNIT_DEFINES_SVH
`ifndef SYNTH
// Checked on every rising edge outside reset.
`define BOS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bilinear opacity splat assertion failed");
// Checked on every rising edge, reset included.
`define BOS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bilinear opacity splat assertion failed");
`else
`define BOS_ASSERT(label, prop)
`define BOS_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ----- design/bos_pkg.sv -----
// Package with the types, constants and helpers of the bilinear opacity splat unit.
package bos_pkg;

    localparam int POS_W     = 14;
    localparam int COLOR_W   = 32;
    localparam int OPA_W     = 8;
    localparam int PIX_W     = 6;
    localparam int NBR_N     = 4;

    localparam int DAB_WIDTH  = 64;
    localparam int DAB_HEIGHT = 64;
    localparam int FRAC_BITS  = 8;

    localparam int INT_W     = POS_W - FRAC_BITS;
    localparam int COORD_W   = (INT_W + 1 > PIX_W) ? INT_W + 1 : PIX_W;
    localparam int DAB_DEPTH = DAB_WIDTH * DAB_HEIGHT;
    localparam int ADDR_W    = $clog2(DAB_DEPTH);
    localparam int WGT_W     = FRAC_BITS + 1;
    localparam int WPROD_W   = 2 * FRAC_BITS + 1;
    localparam int PROD_W    = WPROD_W + OPA_W;

    localparam logic [WGT_W-1:0]  FIX_ONE  = WGT_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (2 * FRAC_BITS - 1);
    localparam logic [OPA_W-1:0]  OPA_MAX  = '1;

    typedef logic [NBR_N-1:0] nbr_mask_t;
    typedef logic [1:0]       nbr_idx_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [COLOR_W-1:0] ink_color;
        logic [OPA_W-1:0]   ink_opacity;
    } particle_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic [OPA_W-1:0]   pixel_opacity;
        logic               last_pixel;
    } pixel_t;

    // Lowest neighbour still to be written; order is top-left, top-right,
    // bottom-left, bottom-right.
    function automatic nbr_idx_t first_nbr(input nbr_mask_t mask);
        nbr_idx_t k;
        k = 2'd3;
        if (mask[2])
            k = 2'd2;
        if (mask[1])
            k = 2'd1;
        if (mask[0])
            k = 2'd0;
        return k;
    endfunction

endpackage

// ----- design/bos_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
module bos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/bos_share.sv -----
// Two-stage multiplier that forms one neighbour's rounded opacity share.
module bos_share
    import bos_pkg::*;
(
    input  logic             clk,
    input  logic [WGT_W-1:0] wx,
    input  logic [WGT_W-1:0] wy,
    input  logic [OPA_W-1:0] opacity,
    output logic [OPA_W-1:0] share
);

    logic [WPROD_W-1:0] wprod_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  rounded;

    always_ff @(posedge clk)
    begin
        wprod_reg <= WPROD_W'(wx) * WPROD_W'(wy);
        prod_reg  <= PROD_W'(wprod_reg) * PROD_W'(opacity);
    end

    // The weight product never exceeds one, so the share fits the opacity width.
    assign rounded = prod_reg + HALF_LSB;
    assign share   = rounded[2*FRAC_BITS +: OPA_W];

endmodule

// ----- design/bilinear_opacity_splat_unit.sv -----
// Bilinear opacity splat unit: after reset a clearing pass writes the dab memory to
// transparent, one entry a cycle, over all DAB_WIDTH*DAB_HEIGHT entries (4096 at 64x64);
// no particle is taken until it ends. Each particle is then accepted while the unit is
// idle, and each of its up to four neighbours inside the dab passes the issue, multiply
// and write states (read the stored opacity, multiply the weights and opacity, add,
// saturate and write back); the write state waits while the pixel output is held by its
// consumer, and no new particle is taken until the last neighbour is written.
// Neighbours go one at a time through the single read-modify-write path of the dab memory.
// Pixels come out top-left, top-right, bottom-left, bottom-right, skipping those
// beyond the dab edge, with last_pixel on the final one.
module bilinear_opacity_splat_unit
    import bos_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      particle_valid,
    output logic      particle_ready,
    input  particle_t particle,
    output logic      pixel_valid,
    input  logic      pixel_ready,
    output pixel_t    pixel
);

`include "bilinear_opacity_splat_unit_defines.svh"

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_MUL,
        S_WRITE
    } state_t;

    state_t               state_reg;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic [INT_W-1:0]     ix_reg;
    logic [INT_W-1:0]     iy_reg;
    logic [FRAC_BITS-1:0] fx_reg;
    logic [FRAC_BITS-1:0] fy_reg;
    logic [COLOR_W-1:0]   color_reg;
    logic [OPA_W-1:0]     op_reg;
    nbr_mask_t            mask_reg;
    nbr_idx_t             k_reg;
    logic                 pixel_valid_reg;
    pixel_t               pixel_reg;

    logic [INT_W-1:0]   acc_ix;
    logic [INT_W-1:0]   acc_iy;
    logic               acc_x0_in;
    logic               acc_x1_in;
    logic               acc_y0_in;
    logic               acc_y1_in;
    nbr_mask_t          acc_mask;
    nbr_mask_t          mask_rest;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [ADDR_W-1:0]  addr;
    logic [WGT_W-1:0]   wx;
    logic [WGT_W-1:0]   wy;
    logic [OPA_W-1:0]   share;
    logic [OPA_W-1:0]   rd_data;
    logic [OPA_W:0]     sum;
    logic [OPA_W-1:0]   sum_sat;
    logic               out_free;
    logic               load_out;
    logic               particle_acc;
    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [OPA_W-1:0]   ram_wdata;

    // Which of the four neighbours of an arriving particle lie inside the dab.
    always_comb
    begin
        acc_ix    = particle.pos_x[POS_W-1:FRAC_BITS];
        acc_iy    = particle.pos_y[POS_W-1:FRAC_BITS];
        acc_x0_in = 32'(acc_ix) < 32'(DAB_WIDTH);
        acc_x1_in = 32'(acc_ix) + 32'd1 < 32'(DAB_WIDTH);
        acc_y0_in = 32'(acc_iy) < 32'(DAB_HEIGHT);
        acc_y1_in = 32'(acc_iy) + 32'd1 < 32'(DAB_HEIGHT);
        acc_mask  = {acc_x1_in & acc_y1_in, acc_x0_in & acc_y1_in,
                     acc_x1_in & acc_y0_in, acc_x0_in & acc_y0_in};
    end

    always_comb
    begin
        cx        = COORD_W'(ix_reg) + COORD_W'(k_reg[0]);
        cy        = COORD_W'(iy_reg) + COORD_W'(k_reg[1]);
        addr      = ADDR_W'(cy) * ADDR_W'(DAB_WIDTH) + ADDR_W'(cx);
        wx        = k_reg[0] ? WGT_W'(fx_reg) : FIX_ONE - WGT_W'(fx_reg);
        wy        = k_reg[1] ? WGT_W'(fy_reg) : FIX_ONE - WGT_W'(fy_reg);
        sum       = (OPA_W+1)'(share) + (OPA_W+1)'(rd_data);
        sum_sat   = sum[OPA_W] ? OPA_MAX : sum[OPA_W-1:0];
        mask_rest = mask_reg & ~(nbr_mask_t'(1) << k_reg);
        out_free  = !pixel_valid_reg || pixel_ready;
        load_out  = (state_reg == S_WRITE) && out_free;
    end

    assign particle_ready = (state_reg == S_IDLE);
    assign particle_acc   = particle_valid && particle_ready;

    assign ram_re    = (state_reg == S_ISSUE);
    assign ram_we    = (state_reg == S_CLEAR) || load_out;
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : addr;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : sum_sat;

    bos_ram #(
        .WIDTH (OPA_W),
        .DEPTH (DAB_DEPTH)
    ) u_dab_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr),
        .rdata (rd_data)
    );

    bos_share u_share (
        .clk     (clk),
        .wx      (wx),
        .wy      (wy),
        .opacity (op_reg),
        .share   (share)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            ix_reg          <= '0;
            iy_reg          <= '0;
            fx_reg          <= '0;
            fy_reg          <= '0;
            color_reg       <= '0;
            op_reg          <= '0;
            mask_reg        <= '0;
            k_reg           <= '0;
            pixel_valid_reg <= 1'b0;
            pixel_reg       <= '0;
        end
        else
        begin
            if (load_out)
            begin
                pixel_valid_reg <= 1'b1;
            end
            else if (pixel_ready)
            begin
                pixel_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    if (clr_cnt_reg == ADDR_W'(DAB_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    end
                end
                S_IDLE:
                begin
                    if (particle_acc)
                    begin
                        ix_reg    <= acc_ix;
                        iy_reg    <= acc_iy;
                        fx_reg    <= particle.pos_x[FRAC_BITS-1:0];
                        fy_reg    <= particle.pos_y[FRAC_BITS-1:0];
                        color_reg <= particle.ink_color;
                        op_reg    <= particle.ink_opacity;
                        mask_reg  <= acc_mask;
                        k_reg     <= first_nbr(acc_mask);
                        // A particle wholly outside the dab gives no pixel.
                        if (acc_mask != '0)
                        begin
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    if (out_free)
                    begin
                        pixel_reg.pixel_x       <= cx[PIX_W-1:0];
                        pixel_reg.pixel_y       <= cy[PIX_W-1:0];
                        pixel_reg.pixel_color   <= color_reg;
                        pixel_reg.pixel_opacity <= sum_sat;
                        pixel_reg.last_pixel    <= (mask_rest == '0);
                        mask_reg                <= mask_rest;
                        k_reg                   <= first_nbr(mask_rest);
                        state_reg <= (mask_rest == '0) ? S_IDLE : S_ISSUE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel       = pixel_reg;

    `BOS_ASSERT_ALWAYS(a_no_particle_while_clearing, (state_reg == S_CLEAR) |-> !particle_ready)
    `BOS_ASSERT(a_accept_starts_work, (particle_acc && acc_mask != '0) |=> (state_reg == S_ISSUE))
    `BOS_ASSERT(a_last_returns_idle, (load_out && mask_rest == '0) |=> (state_reg == S_IDLE))
    `BOS_ASSERT(a_read_held_in_write, ((state_reg == S_WRITE) && $past(state_reg == S_WRITE)) |-> $stable(rd_data))
    `BOS_ASSERT(a_written_pixel_inside, load_out |-> (32'(cx) < 32'(DAB_WIDTH) && 32'(cy) < 32'(DAB_HEIGHT)))

endmodule

// ----- tb/sv/splat_scoreboard_pkg.sv -----
// Scoreboard class that predicts and checks the pixel words of the opacity splat unit.
`timescale 1ns / 1ps
package splat_scoreboard_pkg;
    import bos_pkg::*;

    class splat_scoreboard;
        logic [OPA_W-1:0] dab_level [DAB_DEPTH];
        pixel_t           pixel_q [$];
        int unsigned      mismatch_count;

        function new();
            foreach (dab_level[i])
                dab_level[i] = '0;
            mismatch_count = 0;
        endfunction

        // Spreads one accepted particle over its 2x2 block and queues the pixels it writes.
        function void note_particle(particle_t p);
            int unsigned base_x;
            int unsigned base_y;
            int unsigned frac_x;
            int unsigned frac_y;
            int unsigned col;
            int unsigned row;
            int unsigned level;
            int unsigned wgt_x [2];
            int unsigned wgt_y [2];
            longint unsigned prod;
            int last_k;
            pixel_t pix;
            base_x = int'(p.pos_x) >> FRAC_BITS;
            base_y = int'(p.pos_y) >> FRAC_BITS;
            frac_x = int'(p.pos_x) & ((1 << FRAC_BITS) - 1);
            frac_y = int'(p.pos_y) & ((1 << FRAC_BITS) - 1);
            wgt_x[0] = (1 << FRAC_BITS) - frac_x;
            wgt_x[1] = frac_x;
            wgt_y[0] = (1 << FRAC_BITS) - frac_y;
            wgt_y[1] = frac_y;
            // The last marker belongs to the final neighbour that lies inside the dab.
            last_k = -1;
            for (int k = 0; k < NBR_N; k++)
            begin
                if (base_x + (k & 1) < DAB_WIDTH && base_y + (k >> 1) < DAB_HEIGHT)
                    last_k = k;
            end
            for (int k = 0; k < NBR_N; k++)
            begin
                col = base_x + (k & 1);
                row = base_y + (k >> 1);
                if (col < DAB_WIDTH && row < DAB_HEIGHT)
                begin
                    prod = 64'(wgt_x[k & 1]) * 64'(wgt_y[k >> 1]) * 64'(p.ink_opacity);
                    prod = (prod + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
                    level = int'(prod) + dab_level[row * DAB_WIDTH + col];
                    if (level > OPA_MAX)
                        level = OPA_MAX;
                    dab_level[row * DAB_WIDTH + col] = OPA_W'(level);
                    pix.pixel_x       = PIX_W'(col);
                    pix.pixel_y       = PIX_W'(row);
                    pix.pixel_color   = p.ink_color;
                    pix.pixel_opacity = OPA_W'(level);
                    pix.last_pixel    = (k == last_k);
                    pixel_q.push_back(pix);
                end
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pixel_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("pixel word with none expected: x=%0d y=%0d colour=%h opacity=%0d last=%0b",
                             got.pixel_x, got.pixel_y, got.pixel_color, got.pixel_opacity,
                             got.last_pixel);
                return;
            end
            want = pixel_q.pop_front();
            if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y
                || got.pixel_color !== want.pixel_color
                || got.pixel_opacity !== want.pixel_opacity
                || got.last_pixel !== want.last_pixel)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("pixel word differs, expected x=%0d y=%0d colour=%h opacity=%0d last=%0b",
                             want.pixel_x, want.pixel_y, want.pixel_color, want.pixel_opacity,
                             want.last_pixel);
                    $display("                      actual   x=%0d y=%0d colour=%h opacity=%0d last=%0b",
                             got.pixel_x, got.pixel_y, got.pixel_color, got.pixel_opacity,
                             got.last_pixel);
                end
            end
        endfunction

        function int unsigned outstanding();
            return pixel_q.size();
        endfunction

        function bit clean();
            return mismatch_count == 0 && pixel_q.size() == 0;
        endfunction
    endclass

endpackage

// ----- tb/sv/tb.sv -----
// Top-level testbench that drives particles into the opacity splat unit and checks its pixels.
`timescale 1ns / 1ps
module tb;
    import bos_pkg::*;
    import splat_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic      clk;
    logic      rst_n;
    logic      particle_valid;
    logic      particle_ready;
    particle_t particle;
    logic      pixel_valid;
    logic      pixel_ready;
    pixel_t    pixel;

    splat_scoreboard sb;
    bit          no_idle;
    int unsigned stall_cnt;
    int unsigned hold_cnt;
    int unsigned cycle_cnt;
    int unsigned cluster_x;
    int unsigned cluster_y;

    bilinear_opacity_splat_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .particle_valid (particle_valid),
        .particle_ready (particle_ready),
        .particle       (particle),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .pixel          (pixel)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // A long hold takes precedence over the short stall drawn after each pixel word.
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            pixel_ready <= 1'b0;
            hold_cnt = hold_cnt - 1;
        end
        else if (stall_cnt > 0)
        begin
            pixel_ready <= 1'b0;
            stall_cnt = stall_cnt - 1;
        end
        else
            pixel_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && pixel_ready)
        begin
            sb.check_pixel(pixel);
            stall_cnt = no_idle ? 0 : $urandom_range(0, 5);
        end
    end

    function automatic particle_t mk_particle(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                              logic [COLOR_W-1:0] c, logic [OPA_W-1:0] o);
        particle_t p;
        p.pos_x       = x;
        p.pos_y       = y;
        p.ink_color   = c;
        p.ink_opacity = o;
        return p;
    endfunction

    // Mostly particles around a moving cluster so that opacities build up and saturate.
    function automatic particle_t random_particle();
        particle_t p;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        p.ink_color   = $urandom();
        p.ink_opacity = OPA_W'($urandom_range(0, 255));
        if (sel < 6)
        begin
            p.pos_x = {INT_W'(cluster_x + $urandom_range(0, 3)), FRAC_BITS'($urandom())};
            p.pos_y = {INT_W'(cluster_y + $urandom_range(0, 3)), FRAC_BITS'($urandom())};
        end
        else if (sel < 9)
        begin
            p.pos_x = POS_W'($urandom_range(0, 16383));
            p.pos_y = POS_W'($urandom_range(0, 16383));
        end
        else
        begin
            p.pos_x = POS_W'($urandom_range(0, 16383));
            p.pos_y = POS_W'($urandom_range(0, 16383));
            if ($urandom_range(0, 1) == 1)
                p.pos_x[POS_W-1:FRAC_BITS] = '1;
            else
                p.pos_y[POS_W-1:FRAC_BITS] = '1;
        end
        return p;
    endfunction

    task automatic send_particle(particle_t p);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            @(negedge clk);
            particle_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        particle_valid <= 1'b1;
        particle       <= p;
        do
            @(posedge clk);
        while (!(particle_valid && particle_ready));
        sb.note_particle(p);
    endtask

    initial
    begin
        particle_t directed_q [$];
        sb             = new();
        rst_n          = 1'b0;
        particle_valid = 1'b0;
        particle       = '0;
        pixel_ready    = 1'b0;
        no_idle        = 1'b0;
        stall_cnt      = 0;
        hold_cnt       = 0;
        cycle_cnt      = 0;
        cluster_x      = 20;
        cluster_y      = 20;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Origin, far corner, right and bottom edges, rounding, saturation and zero opacity.
        directed_q.push_back(mk_particle(14'd0, 14'd0, 32'h0000_0000, 8'd255));
        directed_q.push_back(mk_particle(14'h3FFF, 14'h3FFF, 32'hFFFF_FFFF, 8'd255));
        directed_q.push_back(mk_particle({6'd63, 8'd128}, {6'd10, 8'd0}, 32'hA5A5_A5A5, 8'd200));
        directed_q.push_back(mk_particle({6'd10, 8'd64}, {6'd63, 8'd192}, 32'h5A5A_5A5A, 8'd100));
        directed_q.push_back(mk_particle({6'd63, 8'd255}, {6'd0, 8'd1}, 32'h1234_5678, 8'd255));
        directed_q.push_back(mk_particle({6'd0, 8'd1}, {6'd63, 8'd255}, 32'h8765_4321, 8'd254));
        directed_q.push_back(mk_particle({6'd20, 8'd128}, {6'd20, 8'd0}, 32'hDEAD_BEEF, 8'd1));
        directed_q.push_back(mk_particle({6'd30, 8'd128}, {6'd30, 8'd128}, 32'h0F0F_0F0F, 8'd255));
        directed_q.push_back(mk_particle({6'd30, 8'd128}, {6'd30, 8'd128}, 32'hF0F0_F0F0, 8'd255));
        directed_q.push_back(mk_particle({6'd30, 8'd128}, {6'd30, 8'd128}, 32'h3C3C_3C3C, 8'd255));
        directed_q.push_back(mk_particle({6'd30, 8'd128}, {6'd30, 8'd128}, 32'hC3C3_C3C3, 8'd255));
        directed_q.push_back(mk_particle({6'd40, 8'd1}, {6'd40, 8'd255}, 32'h0000_FFFF, 8'd0));
        directed_q.push_back(mk_particle({6'd40, 8'd255}, {6'd40, 8'd1}, 32'hFFFF_0000, 8'd128));
        directed_q.push_back(mk_particle({6'd5, 8'd85}, {6'd7, 8'd170}, 32'h0000_0001, 8'd3));
        directed_q.push_back(mk_particle({6'd5, 8'd1}, {6'd7, 8'd1}, 32'h8000_0000, 8'd255));
        directed_q.push_back(mk_particle(14'h2AAA, 14'h1555, 32'hAAAA_AAAA, 8'hAA));
        directed_q.push_back(mk_particle(14'h1555, 14'h2AAA, 32'h5555_5555, 8'h55));
        directed_q.push_back(mk_particle({6'd63, 8'd0}, {6'd62, 8'd200}, 32'h7777_7777, 8'd77));
        foreach (directed_q[i])
            send_particle(directed_q[i]);

        // Random chunks, some with no idling on either side; one chunk starts with a long
        // receiver hold so that the unit backs up and stalls its particle input.
        for (int chunk = 0; chunk < 8; chunk++)
        begin
            no_idle   = ($urandom_range(0, 3) == 0);
            cluster_x = $urandom_range(0, 60);
            cluster_y = $urandom_range(0, 60);
            if (chunk == 2)
                hold_cnt = 400;
            for (int i = 0; i < 49; i++)
                send_particle(random_particle());
        end
        @(negedge clk);
        particle_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.clean())
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
